// File: rtl/ewmate_pkg.sv
package ewmate_pkg;

   localparam int unsigned TIME_UNITS_DEFAULT = 1000;
   localparam int unsigned WEIGHT_FRAC_BITS   = 8;
   localparam int unsigned WEIGHT_W           = WEIGHT_FRAC_BITS + 1;
   localparam int unsigned RATE_FRAC_BITS     = 8;
   localparam int unsigned TIME_W             = 32;
   localparam int unsigned BITS_W             = 16;
   localparam int unsigned COUNT_W            = 40;
   localparam int unsigned EST_W              = 48;
   localparam int unsigned RATE_W             = 40;
   localparam int unsigned MIN_W              = 16;
   localparam int unsigned CSR_DATA_W         = 16;
   localparam int unsigned BLEND_ACC_W        = EST_W + WEIGHT_FRAC_BITS + 1;

   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

   typedef enum logic {
      CSR_BLEND_WEIGHT = 1'b0,
      CSR_MIN_INTERVAL = 1'b1
   } csr_index_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic                command;
      logic [TIME_W-1:0]   arrival_time_ms;
      logic [BITS_W-1:0]   packet_bits;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   rate_bps;
      logic                estimate_updated;
      logic                tracking_active;
   } rsp_type;

endpackage

// File: rtl/ewma_throughput_estimator_core.sv
// Throughput estimator with an exponentially weighted moving average.
// Input transactions on req_valid/req_stall carry a command (0 = start tracking
// at the given timestamp, 1 = packet arrival), a millisecond timestamp and the
// packet size in bits. Every input transaction yields one output transaction on
// rsp_valid/rsp_stall with the smoothed rate in bits per second, a flag that the
// transaction closed an interval and updated the estimate, and the tracking flag.
// The csr port writes blend_weight (index 0) and min_interval_ms (index 1); it
// is always ready and must only be used while the block is idle.
// A start command, an ignored arrival or an arrival that does not close an
// interval goes from idle to the done state, which loads the output register
// once it is free and returns to idle. An arrival that closes an interval
// runs one shared adder through a shift-add multiply by TIME_UNITS_PER_SECOND (T),
// a restoring divide with a quotient of 40 + clog2(T+1) + 8 bits and two
// shift-add blend passes over the 9-bit weight before the fin state writes the
// estimate; when the estimate was zero, the sample is loaded without blending.
// One item is in flight at a time; req_stall is high from acceptance until the
// result enters the output register, which may still wait on rsp_stall while
// the next transaction is accepted. A stalled output holds its data.
// Synchronous reset clears the estimate, the interval, the tracking flag and
// restores blend_weight to 128 and min_interval_ms to 100.
module ewma_throughput_estimator_core #(
   parameter int unsigned TIME_UNITS_PER_SECOND = ewmate_pkg::TIME_UNITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ewmate_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ewmate_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  ewmate_pkg::csr_index_type             csr_index,
   input  logic [ewmate_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ewmate_pkg::*;

   localparam int unsigned TW = $clog2(TIME_UNITS_PER_SECOND + 1);
   localparam int unsigned NW = COUNT_W + TW;
   localparam int unsigned DW = NW + RATE_FRAC_BITS;
   localparam int unsigned AW = (NW > BLEND_ACC_W) ? NW : BLEND_ACC_W;
   localparam int unsigned MW = (TW > WEIGHT_W) ? TW : WEIGHT_W;
   localparam int unsigned CW = $clog2(DW + 1);

   localparam logic [CW-1:0]      MUL_LAST   = CW'(TW - 1);
   localparam logic [CW-1:0]      DIV_LAST   = CW'(DW - 1);
   localparam logic [CW-1:0]      BLEND_LAST = CW'(WEIGHT_W - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [EST_W-1:0]   EST_MAX    = '1;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_DIV  = 8'b0000_0100,
      ST_SAT  = 8'b0000_1000,
      ST_BLDS = 8'b0001_0000,
      ST_BLDE = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [TIME_W-1:0]    start_ff, start_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [EST_W-1:0]     est_ff, est_in;
   logic                 started_ff, started_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [MIN_W-1:0]     min_ff, min_in;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [AW-1:0]        mcand_ff, mcand_in;
   logic [MW-1:0]        mplier_ff, mplier_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        iter_ff, iter_in;
   logic                 upd_ff, upd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   alu_op_type           alu_op;
   logic [AW-1:0]        alu_a;
   logic [AW-1:0]        alu_b;
   logic [AW-1:0]        alu_result;
   logic                 alu_borrow;

   logic [COUNT_W:0]     count_sum;
   logic [COUNT_W-1:0]   count_sat;
   logic [TIME_W-1:0]    elapsed_now;
   logic [TIME_W-1:0]    trial;
   logic [EST_W-1:0]     sample;
   logic [WEIGHT_W-1:0]  weight_eff;
   logic                 out_free;

   ewmate_alu #(
      .WIDTH(AW)
   ) u_alu (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_result),
      .borrow    (alu_borrow)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign count_sum   = {1'b0, count_ff} + (COUNT_W + 1)'(req_data.packet_bits);
   assign count_sat   = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
   assign elapsed_now = req_data.arrival_time_ms - start_ff;
   assign trial       = {rem_ff[TIME_W-2:0], acc_ff[NW-1]};
   assign sample      = (quo_ff[DW-1:EST_W] != '0) ? EST_MAX : quo_ff[EST_W-1:0];
   assign weight_eff  = (weight_ff > FULL_WEIGHT) ? FULL_WEIGHT : weight_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (state_ff == ST_DIV) begin
         alu_op = ALU_SUB;
         alu_a  = AW'({rem_ff, acc_ff[NW-1]});
         alu_b  = AW'(elapsed_ff);
      end else begin
         alu_op = ALU_ADD;
         alu_a  = acc_ff;
         alu_b  = mcand_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      est_in       = est_ff;
      started_in   = started_ff;
      weight_in    = weight_ff;
      min_in       = min_ff;
      elapsed_in   = elapsed_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      iter_in      = iter_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLEND_WEIGHT: weight_in = csr_data[WEIGHT_W-1:0];
            CSR_MIN_INTERVAL: min_in    = csr_data[MIN_W-1:0];
            default: ;
         endcase
      end

      if (state_ff == ST_MUL || state_ff == ST_BLDS || state_ff == ST_BLDE) begin
         if (mplier_ff[0]) begin
            acc_in = alu_result;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         iter_in   = iter_ff + CW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               upd_in   = 1'b0;
               state_in = ST_DONE;
               if (!req_data.command) begin
                  start_in   = req_data.arrival_time_ms;
                  count_in   = '0;
                  est_in     = '0;
                  started_in = 1'b1;
               end else if (started_ff) begin
                  if (elapsed_now > TIME_W'(min_ff)) begin
                     elapsed_in = elapsed_now;
                     start_in   = req_data.arrival_time_ms;
                     count_in   = '0;
                     acc_in     = '0;
                     mcand_in   = AW'(count_sat);
                     mplier_in  = MW'(TIME_UNITS_PER_SECOND);
                     iter_in    = '0;
                     upd_in     = 1'b1;
                     state_in   = ST_MUL;
                  end else begin
                     count_in = count_sat;
                  end
               end
            end
         end
         ST_MUL: begin
            if (iter_ff == MUL_LAST) begin
               iter_in  = '0;
               rem_in   = '0;
               quo_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = alu_borrow ? trial : alu_result[TIME_W-1:0];
            quo_in  = {quo_ff[DW-2:0], !alu_borrow};
            acc_in  = acc_ff << 1;
            iter_in = iter_ff + CW'(1);
            if (iter_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (est_ff == '0) begin
               est_in   = sample;
               state_in = ST_DONE;
            end else begin
               acc_in    = AW'(FULL_WEIGHT >> 1);
               mcand_in  = AW'(sample);
               mplier_in = MW'(weight_eff);
               iter_in   = '0;
               state_in  = ST_BLDS;
            end
         end
         ST_BLDS: begin
            if (iter_ff == BLEND_LAST) begin
               mcand_in  = AW'(est_ff);
               mplier_in = MW'(FULL_WEIGHT - weight_eff);
               iter_in   = '0;
               state_in  = ST_BLDE;
            end
         end
         ST_BLDE: begin
            if (iter_ff == BLEND_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            est_in   = acc_ff[WEIGHT_FRAC_BITS +: EST_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.rate_bps         = est_ff[RATE_FRAC_BITS +: RATE_W];
               rsp_data_in.estimate_updated = upd_ff;
               rsp_data_in.tracking_active  = started_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         count_ff     <= '0;
         est_ff       <= '0;
         started_ff   <= 1'b0;
         weight_ff    <= WEIGHT_W'(128);
         min_ff       <= MIN_W'(100);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         est_ff       <= est_in;
         started_ff   <= started_in;
         weight_ff    <= weight_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      iter_ff     <= iter_in;
      upd_ff      <= upd_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_update_needs_tracking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.estimate_updated || rsp_data.tracking_active))
      else $error("Estimate update reported without tracking active.");

   a_div_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < elapsed_ff))
      else $error("Divider remainder not below the elapsed time.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input accepted again while a transaction is in flight.");

endmodule

// File: rtl/ewmate_alu.sv
module ewmate_alu #(
   parameter int unsigned WIDTH = 57
) (
   input  ewmate_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]       operand_a,
   input  logic [WIDTH-1:0]       operand_b,
   output logic [WIDTH-1:0]       result,
   output logic                   borrow
);
   import ewmate_pkg::*;

   logic              sub;
   logic [WIDTH:0]    sum;

   assign sub    = (op == ALU_SUB);
   assign sum    = {1'b0, operand_a} + ({1'b0, operand_b} ^ {(WIDTH + 1){sub}})
                   + (WIDTH + 1)'(sub);
   assign result = sum[WIDTH-1:0];
   assign borrow = sub & sum[WIDTH];

endmodule

// File: test/ewma_throughput_estimator_core_checker.sv
package ewmate_tb_pkg;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_ARRIVAL = 1'b1
   } cmd_type;

endpackage

module ewma_throughput_estimator_core_checker
   import ewmate_pkg::*;
   import ewmate_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_W) - 64'd1;
   localparam logic [63:0] EST_LIMIT   = (64'd1 << EST_W) - 64'd1;
   localparam logic [63:0] ROUND_HALF  = 64'd1 << (WEIGHT_FRAC_BITS - 1);
   localparam logic [63:0] FRAC_MASK   = (64'd1 << WEIGHT_FRAC_BITS) - 64'd1;

   logic [WEIGHT_W-1:0] blend_w;
   logic [MIN_W-1:0]    min_gap_ms;
   logic [TIME_W-1:0]   interval_t0;
   logic [COUNT_W-1:0]  interval_bits;
   logic [EST_W-1:0]    est_q8;
   logic                tracking;

   rsp_type expected_rsp[$];

   function automatic logic [EST_W-1:0] rate_sample_q8(input logic [COUNT_W-1:0] count,
                                                      input logic [TIME_W-1:0] elapsed);
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] sum;
      num = 64'(count) * 64'(TIME_UNITS_DEFAULT);
      quo = num / 64'(elapsed);
      rem = num % 64'(elapsed);
      if (quo > (EST_LIMIT >> RATE_FRAC_BITS)) return '1;
      sum = (quo << RATE_FRAC_BITS) + ((rem << RATE_FRAC_BITS) / 64'(elapsed));
      if (sum > EST_LIMIT) return '1;
      return sum[EST_W-1:0];
   endfunction

   function automatic logic [EST_W-1:0] blend_estimate(input logic [EST_W-1:0] sample,
                                                      input logic [EST_W-1:0] est,
                                                      input logic [WEIGHT_W-1:0] w);
      logic [63:0] part_new;
      logic [63:0] part_old;
      logic [63:0] mix;
      if (w >= FULL_WEIGHT) return sample;
      if (w == '0) return est;
      part_new = 64'(w) * 64'(sample);
      part_old = (64'(FULL_WEIGHT) - 64'(w)) * 64'(est);
      mix = (part_new >> WEIGHT_FRAC_BITS) + (part_old >> WEIGHT_FRAC_BITS)
            + (((part_new & FRAC_MASK) + (part_old & FRAC_MASK) + ROUND_HALF)
               >> WEIGHT_FRAC_BITS);
      if (mix > EST_LIMIT) return '1;
      return mix[EST_W-1:0];
   endfunction

   task automatic advance_estimate(input req_type item, output rsp_type res);
      logic [TIME_W-1:0]  elapsed;
      logic [COUNT_W:0]   total;
      logic [EST_W-1:0]   sample;
      logic               closed;
      closed = 1'b0;
      if (item.command == CMD_START) begin
         interval_t0 = item.arrival_time_ms;
         interval_bits = '0;
         est_q8 = '0;
         tracking = 1'b1;
      end else if (tracking) begin
         elapsed = item.arrival_time_ms - interval_t0;
         total = {1'b0, interval_bits} + (COUNT_W + 1)'(item.packet_bits);
         interval_bits = (64'(total) > COUNT_LIMIT) ? '1 : total[COUNT_W-1:0];
         if (elapsed > TIME_W'(min_gap_ms)) begin
            sample = rate_sample_q8(interval_bits, elapsed);
            est_q8 = (est_q8 == '0) ? sample : blend_estimate(sample, est_q8, blend_w);
            interval_bits = '0;
            interval_t0 = item.arrival_time_ms;
            closed = 1'b1;
         end
      end
      res.rate_bps = est_q8[RATE_FRAC_BITS +: RATE_W];
      res.estimate_updated = closed;
      res.tracking_active = tracking;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type next;
      if (reset) begin
         blend_w = WEIGHT_W'(128);
         min_gap_ms = MIN_W'(100);
         interval_t0 = '0;
         interval_bits = '0;
         est_q8 = '0;
         tracking = 1'b0;
         expected_rsp.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected transaction: rate_bps %0d", rsp_data.rate_bps);
               mismatches = mismatches + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.rate_bps !== want.rate_bps) begin
                  $error("rate_bps: expected %0d, got %0d", want.rate_bps, rsp_data.rate_bps);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.estimate_updated !== want.estimate_updated) begin
                  $error("estimate_updated: expected %0d, got %0d",
                         want.estimate_updated, rsp_data.estimate_updated);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.tracking_active !== want.tracking_active) begin
                  $error("tracking_active: expected %0d, got %0d",
                         want.tracking_active, rsp_data.tracking_active);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLEND_WEIGHT: blend_w = csr_data[WEIGHT_W-1:0];
               CSR_MIN_INTERVAL: min_gap_ms = csr_data[MIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_estimate(req_data, next);
            expected_rsp.push_back(next);
         end
         outstanding <= expected_rsp.size();
      end
   end

endmodule

// File: test/ewma_throughput_estimator_core_tb.sv
module ewma_throughput_estimator_core_tb;

   import ewmate_pkg::*;
   import ewmate_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_BLEND_WEIGHT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_count = 0;
   logic                  idle_en = 1'b1;
   logic [TIME_W-1:0]     now_ms = '0;
   logic [MIN_W-1:0]      gap_ms = MIN_W'(100);

   ewma_throughput_estimator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ewma_throughput_estimator_core_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatch_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= idle_en && ($urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ewma_throughput_estimator_core: mismatch");
         $finish;
      end
   end

   task automatic send_req(input logic cmd, input logic [TIME_W-1:0] stamp,
                           input logic [BITS_W-1:0] bits);
      req_type item;
      item.command = cmd;
      item.arrival_time_ms = stamp;
      item.packet_bits = bits;
      while (idle_en && ($urandom_range(99) < 38)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MIN_INTERVAL) gap_ms = value[MIN_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_traffic(input int count);
      int                roll;
      int                size_roll;
      logic              cmd;
      logic [TIME_W-1:0] stamp;
      logic [BITS_W-1:0] bits;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         size_roll = $urandom_range(9);
         if (size_roll < 2) bits = '1;
         else if (size_roll == 2) bits = '0;
         else bits = BITS_W'($urandom_range(0, 65535));
         cmd = CMD_ARRIVAL;
         if (roll < 4) begin
            cmd = CMD_START;
            now_ms = $urandom();
            stamp = now_ms;
         end else if (roll < 8) begin
            stamp = $urandom();
         end else begin
            if (roll < 14) now_ms = now_ms + TIME_W'(gap_ms) + TIME_W'($urandom_range(0, 1));
            else now_ms = now_ms + TIME_W'($urandom_range(0, gap_ms / 2 + 3));
            stamp = now_ms;
         end
         send_req(cmd, stamp, bits);
         if ($urandom_range(149) == 0) settle();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Arrivals before any start command are ignored.
      send_req(CMD_ARRIVAL, 32'h0000_0005, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'hFFFF_FFFF, 16'h0000);
      send_req(CMD_START, 32'hFFFF_FFF0, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'h0000_0010, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'h0000_0054, 16'h1234);
      send_req(CMD_ARRIVAL, 32'h0000_0055, 16'h0000);
      send_req(CMD_ARRIVAL, 32'h0000_011D, 16'h8000);
      // A timestamp that goes backwards looks like a very long interval.
      send_req(CMD_ARRIVAL, 32'h0000_011C, 16'hFFFF);
      send_req(CMD_START, 32'h0000_0000, 16'h0000);
      send_req(CMD_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF);

      settle();
      write_csr(CSR_BLEND_WEIGHT, 16'h0000);
      write_csr(CSR_MIN_INTERVAL, 16'h0000);
      send_req(CMD_ARRIVAL, 32'hFFFF_FFFF, 16'h0064);
      send_req(CMD_ARRIVAL, 32'h0000_0000, 16'h0064);

      // Weights above one act as one; a zero sample then zeroes the estimate.
      settle();
      write_csr(CSR_BLEND_WEIGHT, 16'hFFFF);
      write_csr(CSR_MIN_INTERVAL, 16'h0001);
      send_req(CMD_ARRIVAL, 32'h0000_0002, 16'h0000);
      send_req(CMD_ARRIVAL, 32'h0000_0004, 16'h012C);
      send_req(CMD_ARRIVAL, 32'h0000_0006, 16'h0028);

      settle();
      write_csr(CSR_BLEND_WEIGHT, 16'h0100);
      write_csr(CSR_MIN_INTERVAL, 16'hFFFF);
      send_req(CMD_START, 32'h8000_0000, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'h8000_FFFF, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'h8001_0000, 16'hFFFF);

      settle();
      write_csr(CSR_BLEND_WEIGHT, 16'h0001);
      write_csr(CSR_MIN_INTERVAL, 16'h0000);
      send_req(CMD_ARRIVAL, 32'h8001_0005, 16'hFFFF);
      send_req(CMD_ARRIVAL, 32'h8001_0009, 16'h0003);
      now_ms = 32'h8001_0009;

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0: begin
               write_csr(CSR_BLEND_WEIGHT, 16'd128);
               write_csr(CSR_MIN_INTERVAL, 16'd100);
            end
            1: begin
               write_csr(CSR_BLEND_WEIGHT, 16'd0);
               write_csr(CSR_MIN_INTERVAL, 16'd0);
            end
            2: begin
               write_csr(CSR_BLEND_WEIGHT, 16'd256);
               write_csr(CSR_MIN_INTERVAL, 16'hFFFF);
            end
            3: begin
               write_csr(CSR_BLEND_WEIGHT, 16'd1);
               write_csr(CSR_MIN_INTERVAL, 16'd1);
            end
            4: begin
               write_csr(CSR_BLEND_WEIGHT, 16'd255);
               write_csr(CSR_MIN_INTERVAL, 16'd10);
            end
            5: begin
               write_csr(CSR_BLEND_WEIGHT, CSR_DATA_W'($urandom_range(0, 65535)));
               write_csr(CSR_MIN_INTERVAL, CSR_DATA_W'($urandom_range(0, 2000)));
            end
            6: begin
               write_csr(CSR_BLEND_WEIGHT, CSR_DATA_W'($urandom_range(0, 511)));
               write_csr(CSR_MIN_INTERVAL, CSR_DATA_W'($urandom_range(0, 300)));
            end
            default: begin
               write_csr(CSR_BLEND_WEIGHT, 16'hFFFF);
               write_csr(CSR_MIN_INTERVAL, CSR_DATA_W'($urandom_range(0, 65535)));
            end
         endcase
         idle_en <= (phase != 3);
         run_traffic(244);
      end

      settle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ewma_throughput_estimator_core: match");
      end else begin
         $display("ewma_throughput_estimator_core: mismatch");
      end
      $finish;
   end

endmodule
